// ===== sv/fbds_pkg.sv =====
// Shared widths, constants, datapath commands and status for the baud divider search.
package fbds_pkg;

  localparam int BaudW = 23;
  localparam int ClkW  = 27;
  localparam int DlW   = 16;
  localparam int NibW  = 4;
  localparam int DvdW  = 32;  // dividend and quotient width
  localparam int DvsW  = 28;  // divisor and remainder width
  localparam int CntW  = 5;   // one divider step per dividend bit

  localparam logic [ClkW-1:0] ClkReset = 27'd100000000;
  localparam logic [NibW-1:0] MulFirst = 4'd1;
  localparam logic [NibW-1:0] MulLast  = 4'd15;
  localparam logic [NibW-1:0] AddLast  = 4'd14;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,       // capture baud, reset best and candidate
    OP_DIV_BASE,   // clock / (16 * baud)
    OP_BASE_DONE,  // take truncated quotient as default latch
    OP_PREP,       // mul * clock, baud * (add + mul)
    OP_DIV_LATCH,  // scaled clock / (baud * (add + mul))
    OP_LATCH,      // round and clamp divisor latch
    OP_DIV_RATE,   // clock * mul / (dl * (add + mul) * 8)
    OP_CMP,        // error compare, step to next candidate
    OP_OUT         // load output word
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic baud_zero;
    logic div_done;
    logic rem_nz;
    logic last_cand;
  } sts_t;

endpackage

// ===== sv/fractional_baud_divider_search.sv =====
// Top level of the UART fractional baud divider search.
//
//  port group   dir   payload
//  s_axis       in    tdata[22:0] requested_baud
//  m_axis       out   tdata[15:0] divisor_latch, [19:16] multiplier_value, [23:20] add_value
//  cfg          in    cfg_wdata_i[26:0] peripheral_clock_hz, written when cfg_we_i
//
//  One word at a time. A shared 32-step serial divider sets the pace: an exact division
//  answers after the base division alone; otherwise 120 candidates follow, each with a
//  latch and a rate division. A zero baud answers without using the divider.
//  Reset loads the clock register with 100000000; no clearing pass.
//  A finished word waits in the output register; the next input word is taken meanwhile,
//  and the search stalls before its output only if that word has not been taken.
module fractional_baud_divider_search (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fbds_pkg::ClkW-1:0]   cfg_wdata_i,     // peripheral_clock_hz
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [23:0]                 s_axis_tdata_i,  // requested_baud[22:0], pad
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [23:0]                 m_axis_tdata_o   // divisor_latch, multiplier, add
);

  fbds_pkg::cmd_t             cmd;
  fbds_pkg::sts_t             sts;
  logic [fbds_pkg::DlW-1:0]   dl;
  logic [fbds_pkg::NibW-1:0]  mul, add;

  fbds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fbds_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .baud_i      (s_axis_tdata_i[fbds_pkg::BaudW-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .dl_o        (dl),
    .mul_o       (mul),
    .add_o       (add)
  );

  assign m_axis_tdata_o = {add, mul, dl};

endmodule

// ===== sv/fbds_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module fbds_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fbds_pkg::DvdW-1:0]  dividend_i,
  input  logic [fbds_pkg::DvsW-1:0]  divisor_i,
  output logic [fbds_pkg::DvdW-1:0]  quo_o,
  output logic [fbds_pkg::DvsW-1:0]  rem_o,
  output logic                       done_o
);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [fbds_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [fbds_pkg::DvdW-1:0] quo_q, quo_d;
  logic [fbds_pkg::DvsW-1:0] rem_q, rem_d;
  logic [fbds_pkg::DvsW-1:0] dvs_q, dvs_d;
  logic [fbds_pkg::DvsW:0]   partial;
  logic [fbds_pkg::DvsW+1:0] diff;

  assign partial = {rem_q, quo_q[fbds_pkg::DvdW-1]};
  assign diff    = {1'b0, partial} - {2'b00, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // partial < 2 * divisor, so a failed subtract leaves it in DvsW bits
      if (!diff[fbds_pkg::DvsW+1]) begin
        rem_d = diff[fbds_pkg::DvsW-1:0];
        quo_d = {quo_q[fbds_pkg::DvdW-2:0], 1'b1};
      end else begin
        rem_d = partial[fbds_pkg::DvsW-1:0];
        quo_d = {quo_q[fbds_pkg::DvdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

// ===== sv/fbds_datapath.sv =====
// Datapath: clock register, candidate registers, multipliers, shared divider, best tracking.
module fbds_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fbds_pkg::ClkW-1:0]   cfg_wdata_i,
  input  logic [fbds_pkg::BaudW-1:0]  baud_i,
  input  fbds_pkg::cmd_t              cmd_i,
  output fbds_pkg::sts_t              sts_o,
  output logic [fbds_pkg::DlW-1:0]    dl_o,
  output logic [fbds_pkg::NibW-1:0]   mul_o,
  output logic [fbds_pkg::NibW-1:0]   add_o
);

  logic [fbds_pkg::ClkW-1:0]  clk_q;
  logic [fbds_pkg::BaudW-1:0] baud_q;
  logic [fbds_pkg::NibW-1:0]  mul_q, mul_d;
  logic [fbds_pkg::NibW-1:0]  add_q, add_d;
  logic [30:0]                mc_q;
  logic [fbds_pkg::DvsW-1:0]  den_q;
  logic [fbds_pkg::DlW-1:0]   dl_q, dl_d;
  logic [fbds_pkg::BaudW-1:0] err_min_q;
  logic [fbds_pkg::DlW-1:0]   best_dl_q;
  logic [fbds_pkg::NibW-1:0]  best_mul_q, best_add_q;
  logic [fbds_pkg::DlW-1:0]   out_dl_q;
  logic [fbds_pkg::NibW-1:0]  out_mul_q, out_add_q;

  logic                       div_start, div_done;
  logic [fbds_pkg::DvdW-1:0]  div_dividend, div_quo;
  logic [fbds_pkg::DvsW-1:0]  div_divisor, div_rem;

  logic [fbds_pkg::NibW:0]    sum;
  logic [20:0]                dl_sum;
  logic [27:0]                lat_shift;
  logic [28:0]                lat_round;
  logic [fbds_pkg::DlW-1:0]   lat_raw;
  logic [fbds_pkg::DvdW:0]    rate_round;
  logic [fbds_pkg::DvdW-1:0]  rate, err;
  logic                       better;

  assign sum    = {1'b0, add_q} + {1'b0, mul_q};
  assign dl_sum = {5'd0, dl_q} * {16'd0, sum};

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (cmd_i.op)
      fbds_pkg::OP_DIV_BASE: begin
        div_start    = 1'b1;
        div_dividend = {5'd0, clk_q};
        div_divisor  = {1'b0, baud_q, 4'd0};
      end
      fbds_pkg::OP_DIV_LATCH: begin
        div_start    = 1'b1;
        // bit 31 of 2*mul*clk picks 2x or 4x scaling
        div_dividend = mc_q[30] ? {mc_q, 1'b0} : {mc_q[29:0], 2'b00};
        div_divisor  = den_q;
      end
      fbds_pkg::OP_DIV_RATE: begin
        div_start    = 1'b1;
        div_dividend = {1'b0, mc_q};
        div_divisor  = {4'd0, dl_sum, 3'd0};
      end
      default: begin
      end
    endcase
  end

  fbds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quo_o      (div_quo),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  // divisor latch: round the scaled quotient, keep 16 bits, clamp
  always_comb begin
    lat_shift = mc_q[30] ? div_quo[31:4] : {1'b0, div_quo[31:5]};
    lat_round = ({1'b0, lat_shift} + 29'd1) >> 1;
    lat_raw   = lat_round[fbds_pkg::DlW-1:0];
    dl_d      = lat_raw;
    if (lat_raw == '0) begin
      dl_d = 16'd1;
    end
    if (add_q != '0 && dl_d < 16'd2) begin
      dl_d = 16'd2;
    end
  end

  assign rate_round = ({1'b0, div_quo} + 33'd1) >> 1;
  assign rate       = rate_round[fbds_pkg::DvdW-1:0];
  assign err        = (rate >= {9'd0, baud_q}) ? rate - {9'd0, baud_q}
                                               : {9'd0, baud_q} - rate;
  assign better     = err < {9'd0, err_min_q};

  always_comb begin
    mul_d = mul_q;
    add_d = add_q;
    if (add_q == mul_q - 1'b1) begin
      mul_d = mul_q + 1'b1;
      add_d = '0;
    end else begin
      add_d = add_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_q <= fbds_pkg::ClkReset;
    end else if (cfg_we_i) begin
      clk_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      fbds_pkg::OP_LOAD: begin
        baud_q     <= baud_i;
        err_min_q  <= baud_i;
        mul_q      <= fbds_pkg::MulFirst;
        add_q      <= '0;
        best_dl_q  <= '0;
        best_mul_q <= fbds_pkg::MulFirst;
        best_add_q <= '0;
      end
      fbds_pkg::OP_BASE_DONE: begin
        best_dl_q <= div_quo[fbds_pkg::DlW-1:0];
      end
      fbds_pkg::OP_PREP: begin
        mc_q  <= {27'd0, mul_q} * {4'd0, clk_q};
        den_q <= {5'd0, baud_q} * {23'd0, sum};
      end
      fbds_pkg::OP_LATCH: begin
        dl_q <= dl_d;
      end
      fbds_pkg::OP_CMP: begin
        if (better) begin
          err_min_q  <= err[fbds_pkg::BaudW-1:0];
          best_dl_q  <= dl_q;
          best_mul_q <= mul_q;
          best_add_q <= add_q;
        end
        mul_q <= mul_d;
        add_q <= add_d;
      end
      fbds_pkg::OP_OUT: begin
        out_dl_q  <= best_dl_q;
        out_mul_q <= best_mul_q;
        out_add_q <= best_add_q;
      end
      default: begin
      end
    endcase
  end

  assign sts_o.baud_zero = (baud_q == '0);
  assign sts_o.div_done  = div_done;
  assign sts_o.rem_nz    = (div_rem != '0);
  assign sts_o.last_cand = (mul_q == fbds_pkg::MulLast) && (add_q == fbds_pkg::AddLast);

  assign dl_o  = out_dl_q;
  assign mul_o = out_mul_q;
  assign add_o = out_add_q;

endmodule

// ===== sv/fbds_ctrl.sv =====
// Sequencer for the divider search plus the input and output handshakes.
module fbds_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  fbds_pkg::sts_t sts_i,
  output fbds_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BGO   = 4'd1;
  localparam logic [3:0] S_BWAIT = 4'd2;
  localparam logic [3:0] S_PREP  = 4'd3;
  localparam logic [3:0] S_LGO   = 4'd4;
  localparam logic [3:0] S_LWAIT = 4'd5;
  localparam logic [3:0] S_RGO   = 4'd6;
  localparam logic [3:0] S_RWAIT = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = fbds_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = fbds_pkg::OP_LOAD;
          state_d  = S_BGO;
        end
      end
      S_BGO: begin
        if (sts_i.baud_zero) begin
          state_d = S_OUT;
        end else begin
          cmd_o.op = fbds_pkg::OP_DIV_BASE;
          state_d  = S_BWAIT;
        end
      end
      S_BWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.op = fbds_pkg::OP_BASE_DONE;
          state_d  = sts_i.rem_nz ? S_PREP : S_OUT;
        end
      end
      S_PREP: begin
        cmd_o.op = fbds_pkg::OP_PREP;
        state_d  = S_LGO;
      end
      S_LGO: begin
        cmd_o.op = fbds_pkg::OP_DIV_LATCH;
        state_d  = S_LWAIT;
      end
      S_LWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.op = fbds_pkg::OP_LATCH;
          state_d  = S_RGO;
        end
      end
      S_RGO: begin
        cmd_o.op = fbds_pkg::OP_DIV_RATE;
        state_d  = S_RWAIT;
      end
      S_RWAIT: begin
        if (sts_i.div_done) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.op = fbds_pkg::OP_CMP;
        state_d  = sts_i.last_cand ? S_OUT : S_PREP;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.op = fbds_pkg::OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.op == fbds_pkg::OP_OUT) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !sts_i.div_done)
    else $error("divider finished while sequencer idle");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while search running");

  a_out_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> cmd_o.op != fbds_pkg::OP_OUT)
    else $error("output word overwritten before taken");

  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result valid raised outside output state");

endmodule

// ===== test/fbds_checker.sv =====
// Checker for the baud divider search: predicts each answer and compares output words.
`timescale 1ns / 100ps

module fbds_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [fbds_pkg::ClkW-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid_i,
  input  logic                      s_axis_tready_i,
  input  logic [23:0]               s_axis_tdata_i,
  input  logic                      m_axis_tvalid_i,
  input  logic                      m_axis_tready_i,
  input  logic [23:0]               m_axis_tdata_i,
  output int                        pending_o,
  output int                        errors_o
);
  import fbds_pkg::*;

  typedef struct {
    logic [BaudW-1:0] baud;
    logic [DlW-1:0]   latch;
    logic [NibW-1:0]  mul;
    logic [NibW-1:0]  add;
  } divisor_t;

  divisor_t         divisor_q[$];
  logic [ClkW-1:0]  clock_hz;
  int               mismatches;

  // Exhaustive search over multiplier/add pairs, all math in wrapping 32 bits.
  function automatic divisor_t search_divisor(input logic [BaudW-1:0] baud_in,
                                               input logic [ClkW-1:0] clk_in);
    divisor_t    res;
    logic [31:0] c, b, base, den, scaled, dl, rate, err, err_min;
    logic [31:0] dl_best, mul_best, add_best;
    c        = 32'(clk_in);
    b        = 32'(baud_in);
    dl_best  = '0;
    mul_best = 32'(MulFirst);
    add_best = '0;
    if (b != 0) begin
      base    = 32'd16 * b;
      dl_best = (c / base) & 32'hFFFF;
      if ((c % base) != 0) begin
        err_min = b;
        for (int m = int'(MulFirst); m <= int'(MulLast); m++) begin
          for (int a = 0; a < m; a++) begin
            den    = b * 32'(a + m);
            scaled = 32'(2 * m) * c;
            if (scaled[31]) begin
              dl = ((scaled / den) / 32'd16 + 32'd1) / 32'd2;
            end else begin
              scaled = 32'(4 * m) * c;
              dl     = ((scaled / den) / 32'd32 + 32'd1) / 32'd2;
            end
            dl = dl & 32'hFFFF;
            if (dl == 0) dl = 32'd1;
            if (a > 0 && dl < 32'd2) dl = 32'd2;
            rate = ((c * 32'(m)) / (dl * 32'(a + m) * 32'd8) + 32'd1) / 32'd2;
            err  = (rate >= b) ? rate - b : b - rate;
            if (err < err_min) begin
              err_min  = err;
              dl_best  = dl;
              mul_best = 32'(m);
              add_best = 32'(a);
            end
          end
        end
      end
    end
    res.baud  = baud_in;
    res.latch = dl_best[DlW-1:0];
    res.mul   = mul_best[NibW-1:0];
    res.add   = add_best[NibW-1:0];
    return res;
  endfunction

  initial begin
    pending_o  = 0;
    errors_o   = 0;
    mismatches = 0;
    clock_hz   = ClkReset;
  end

  always @(posedge clk_i) begin
    divisor_t exp_d;
    logic [DlW-1:0]  got_latch;
    logic [NibW-1:0] got_mul, got_add;
    if (!rst_ni) begin
      clock_hz = ClkReset;
      divisor_q.delete();
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        divisor_q.push_back(search_divisor(s_axis_tdata_i[BaudW-1:0], clock_hz));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got_latch = m_axis_tdata_i[15:0];
        got_mul   = m_axis_tdata_i[19:16];
        got_add   = m_axis_tdata_i[23:20];
        if (divisor_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected output word dl=%0d mul=%0d add=%0d",
                     $time, got_latch, got_mul, got_add);
          mismatches++;
        end else begin
          exp_d = divisor_q.pop_front();
          if (got_latch !== exp_d.latch || got_mul !== exp_d.mul ||
              got_add !== exp_d.add) begin
            if (mismatches < 10)
              $display("%0t: baud %0d: exp dl=%0d mul=%0d add=%0d got dl=%0d mul=%0d add=%0d",
                       $time, exp_d.baud, exp_d.latch, exp_d.mul, exp_d.add,
                       got_latch, got_mul, got_add);
            mismatches++;
          end
        end
      end
      // config only moves while idle, so predictions already made are unaffected
      if (cfg_we_i) clock_hz = cfg_wdata_i;
    end
    pending_o <= divisor_q.size();
    errors_o  <= mismatches;
  end

endmodule

// ===== test/tb_fractional_baud_divider_search.sv =====
// Testbench top for the baud divider search: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_fractional_baud_divider_search;
  import fbds_pkg::*;

  localparam int IdleLimit  = 100000;
  localparam int HoldCycles = 25000;
  localparam int BaudMax    = 8388607;
  localparam int ClkMax     = 134217727;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [ClkW-1:0]  cfg_wdata;
  logic             s_tvalid;
  logic             s_tready;
  logic [23:0]      s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [23:0]      m_tdata;
  int               pending;
  int               errors;

  int               burst_left;
  logic [ClkW-1:0]  clock_hz;
  logic             hold_req;
  int               hold_left;
  int               pattern_left;
  int               ready_pct;
  int               idle_cycles;
  int unsigned      std_bauds[8] = '{300, 1200, 2400, 9600, 19200, 57600, 115200, 921600};

  fractional_baud_divider_search dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  fbds_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .pending_o       (pending),
    .errors_o        (errors)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Offer one word; bursts of random length, with random idle gaps between them.
  task automatic send_word(input logic [BaudW-1:0] baud);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 6);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, baud};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    burst_left--;
  endtask

  // Stop offering and wait until every expected word has come back.
  task automatic drain_results();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_clock(input logic [ClkW-1:0] hz);
    cfg_we    <= 1'b1;
    cfg_wdata <= hz;
    clock_hz  = hz;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [BaudW-1:0] pick_baud();
    int unsigned b, k, w;
    case ($urandom_range(0, 9))
      0, 1, 2: b = $urandom_range(1, BaudMax);
      3, 4:    b = std_bauds[$urandom_range(0, 7)];
      5:       b = $urandom_range(1, 300);
      6, 7: begin
        // baud = clock / (16 * k), truncated: fast path only when it divides evenly
        k = $urandom_range(1, 64);
        b = clock_hz / (16 * k);
        if (b == 0) b = 1;
      end
      8: begin
        w = $urandom_range(1, BaudW);
        b = $urandom & ((32'd1 << w) - 1);
      end
      default: b = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4000);
    endcase
    return b[BaudW-1:0];
  endfunction

  // Receiver: long hold-off on request, otherwise a ready pattern of varying density.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(20, 200);
        case ($urandom_range(0, 4))
          0, 1:    ready_pct = 100;
          2:       ready_pct = 75;
          3:       ready_pct = 40;
          default: ready_pct = 10;
        endcase
      end
      pattern_left--;
      m_tready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("fractional_baud_divider_search test failed");
      $finish;
    end
  end

  initial begin
    logic [ClkW-1:0] hz;
    burst_left   = 0;
    clock_hz     = ClkReset;
    hold_req     = 1'b0;
    hold_left    = 0;
    pattern_left = 0;
    ready_pct    = 100;
    idle_cycles  = 0;
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    m_tready  <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset clock value: extremes of baud, zero baud, exact and inexact rates
    send_word(23'd0);
    send_word(23'd1);
    send_word(23'(BaudMax));
    send_word(23'd9600);
    send_word(23'd115200);
    send_word(23'd6250);
    send_word(23'd1562500);
    send_word(23'h400000);
    send_word(23'd2400);
    drain_results();

    // slowest clock: no candidate beats the truncated quotient
    write_clock(27'd1);
    send_word(23'd1);
    send_word(23'd2);
    send_word(23'(BaudMax));
    send_word(23'd0);
    drain_results();

    // fastest clock: scaled products reach bit 31
    write_clock(27'(ClkMax));
    send_word(23'd1);
    send_word(23'd115200);
    send_word(23'(BaudMax));
    drain_results();

    // zero clock divides exactly
    write_clock(27'd0);
    send_word(23'd9600);
    send_word(23'd1);
    drain_results();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       hz = 27'($urandom_range(1, ClkMax));
        1:       hz = 27'd48000000;
        2:       hz = 27'($urandom_range(1, ClkMax));
        3:       hz = 27'($urandom_range(1, 1000000));
        default: hz = 27'd18432000;
      endcase
      write_clock(hz);
      // output side blocked for a long stretch while words keep coming
      if (ph == 1) hold_req = 1'b1;
      for (int i = 0; i < 20; i++) begin
        if (ph == 1 && i < 4)
          send_word(23'($urandom_range(1000, 200000)) | 23'd1);
        else
          send_word(pick_baud());
      end
      drain_results();
    end

    repeat (50) @(posedge clk_i);
    if (errors == 0)
      $display("fractional_baud_divider_search test passed");
    else
      $display("fractional_baud_divider_search test failed");
    $finish;
  end

endmodule
